FILE: design/epa_pkg.sv
// ----------------------------------------------------------------------------
// epa_pkg
// Shared types and constants of the edge partition assigner.
// ----------------------------------------------------------------------------
package epa_pkg;

   localparam int MAX_PARTITIONS = 32;
   localparam int IDX_W          = $clog2(MAX_PARTITIONS);
   localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

   localparam int CLU_W   = 5;
   localparam int DEG_W   = 32;
   localparam int VTX_W   = 32;
   localparam int LOAD_W  = 32;
   localparam int LIMIT_W = 32;
   localparam int PCNT_W  = 6;
   localparam int PART_W  = 5;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from byte address bit 2
   localparam logic REG_HALF_LOAD  = 1'b0;
   localparam logic REG_PART_COUNT = 1'b1;

   localparam logic [LIMIT_W-1:0] HALF_LOAD_RESET = '1;
   localparam logic [PCNT_W-1:0]  PART_COUNT_RESET = PCNT_W'(32);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic decide;
      logic scan;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic both_full;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

FILE: design/epa_ctrl.sv
// ----------------------------------------------------------------------------
// epa_ctrl
// Sequencer of the edge partition assigner: capture, decide, scan, update,
// finish.
// ----------------------------------------------------------------------------
module epa_ctrl import epa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.bad) begin
               state_in = ST_FINISH;
            end else if (status.both_full) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold the result until the output register can take it
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/epa_dpath.sv
// ----------------------------------------------------------------------------
// epa_dpath
// Datapath: load counters, choice logic, least-load scan, output register.
// ----------------------------------------------------------------------------
module epa_dpath import epa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [LIMIT_W-1:0]    half_load_limit,
   input  logic [PCNT_W-1:0]     partition_count,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   // load memory; entries not yet written read as zero
   logic [LOAD_W-1:0]         load_mem [MAX_PARTITIONS];
   logic [MAX_PARTITIONS-1:0] vld_ff;

   logic [LOAD_W-1:0] rd_a_ff, rd_b_ff;
   logic              rd_a_vld_ff, rd_b_vld_ff;
   logic [LOAD_W-1:0] ld_a, ld_b;
   logic [IDX_W-1:0]  addr_a, addr_b;

   logic [CLU_W-1:0]  src_cl, dst_cl;
   logic [CLU_W-1:0]  src_cl_ff, dst_cl_ff;
   logic [DEG_W-1:0]  src_deg_ff, dst_deg_ff;
   logic [VTX_W-1:0]  src_vtx_ff, dst_vtx_ff;
   logic              bad_ff, bad_in;

   logic [CNT_W-1:0]  k_eff;
   logic              full_a, full_b;
   logic              pick_src;

   logic [IDX_W-1:0]  sel_ff;
   logic [LOAD_W-1:0] sel_load_ff;

   logic [CNT_W-1:0]  scan_idx_ff;
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;

   logic              out_vld_ff;
   logic [PART_W-1:0] out_part_ff;
   logic              out_bad_ff;

   assign src_cl = req_tdata[4:0];
   assign dst_cl = req_tdata[9:5];

   always_comb begin
      if (32'(partition_count) > 32'(MAX_PARTITIONS)) begin
         k_eff = CNT_W'(MAX_PARTITIONS);
      end else begin
         k_eff = CNT_W'(partition_count);
      end
   end

   assign bad_in = (32'(src_cl) >= 32'(k_eff)) || (32'(dst_cl) >= 32'(k_eff));

   // port A serves the endpoint read and then the scan
   assign addr_a = cmd.capture ? IDX_W'(src_cl) : scan_idx_ff[IDX_W-1:0];
   assign addr_b = IDX_W'(dst_cl);

   always_ff @(posedge clock) begin
      rd_a_ff <= load_mem[addr_a];
      rd_b_ff <= load_mem[addr_b];
      if (cmd.update) begin
         if (sel_load_ff != '1) begin
            load_mem[sel_ff] <= sel_load_ff + LOAD_W'(1);
         end else begin
            load_mem[sel_ff] <= sel_load_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_a_vld_ff <= 1'b0;
         rd_b_vld_ff <= 1'b0;
      end else begin
         rd_a_vld_ff <= vld_ff[addr_a];
         rd_b_vld_ff <= vld_ff[addr_b];
         if (cmd.update) begin
            vld_ff[sel_ff] <= 1'b1;
         end
      end
   end

   assign ld_a = rd_a_vld_ff ? rd_a_ff : '0;
   assign ld_b = rd_b_vld_ff ? rd_b_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_cl_ff  <= src_cl;
         dst_cl_ff  <= dst_cl;
         src_deg_ff <= req_tdata[41:10];
         dst_deg_ff <= req_tdata[73:42];
         src_vtx_ff <= req_tdata[105:74];
         dst_vtx_ff <= req_tdata[137:106];
         bad_ff     <= bad_in;
      end
   end

   assign full_a = ld_a >= half_load_limit;
   assign full_b = ld_b >= half_load_limit;

   always_comb begin
      if (full_a) begin
         pick_src = 1'b0;
      end else if (full_b) begin
         pick_src = 1'b1;
      end else if (src_deg_ff < dst_deg_ff) begin
         pick_src = 1'b1;
      end else if (src_deg_ff == dst_deg_ff) begin
         pick_src = src_vtx_ff < dst_vtx_ff;
      end else begin
         pick_src = 1'b0;
      end
   end

   // choice register, also carries the running minimum of the scan
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         if (bad_ff) begin
            sel_ff <= '0;
         end else if (pick_src) begin
            sel_ff      <= IDX_W'(src_cl_ff);
            sel_load_ff <= ld_a;
         end else begin
            sel_ff      <= IDX_W'(dst_cl_ff);
            sel_load_ff <= ld_b;
         end
      end else if (cmd.scan && cmp_vld_ff) begin
         if (cmp_idx_ff == '0 || ld_a < sel_load_ff) begin
            sel_ff      <= cmp_idx_ff;
            sel_load_ff <= ld_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else if (cmd.decide) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else if (cmd.scan) begin
         if (scan_idx_ff < k_eff) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            cmp_vld_ff  <= 1'b1;
         end else begin
            cmp_vld_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         cmp_idx_ff <= scan_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_part_ff <= PART_W'(sel_ff);
         out_bad_ff  <= bad_ff;
      end
   end

   assign status.bad       = bad_ff;
   assign status.both_full = full_a && full_b;
   assign status.scan_done = (scan_idx_ff == k_eff) && !cmp_vld_ff;
   assign status.out_free  = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PART_W){1'b0}}, out_part_ff};
   assign rsp_tuser  = out_bad_ff;

endmodule

FILE: design/edge_partition_assigner.sv
// ----------------------------------------------------------------------------
// edge_partition_assigner
// Assigns each streamed graph edge to a partition by cluster, load and degree.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one edge per word: both endpoints' cluster ids, degrees and
//   vertex ids. rsp_* returns one word per edge: the chosen partition in
//   tdata and the bad-cluster flag in tuser. csr_* is an APB-style port with
//   half_load_limit at byte address 0 and partition_count at address 4;
//   write it only while no edge is in flight.
//   After accept, an edge with a bad cluster goes from decide straight to
//   finish; one whose choice follows from cluster loads, degrees or vertex
//   ids goes through decide, update and finish; when both clusters are full,
//   a least-load scan over the effective partition count, reading one
//   counter per cycle through one memory port, comes between decide and
//   update. One edge is worked on at a time; req_tready is high only while
//   idle.
//   The result sits in an output register: a new edge is accepted while the
//   previous result waits, and that edge holds in its finish step while
//   rsp_tready stays low.
//   Reset clears all load counters (through per-entry valid bits, no clearing
//   pass), sets half_load_limit to all ones and partition_count to 32.
// ----------------------------------------------------------------------------
module edge_partition_assigner import epa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // src_cluster[4:0], dst_cluster[9:5], src_degree[41:10],
   // dst_degree[73:42], src_vertex[105:74], dst_vertex[137:106], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // partition[4:0], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // bad_cluster[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LIMIT_W-1:0] half_load_ff;
   logic [PCNT_W-1:0]  part_count_ff;
   logic               csr_wr;
   logic               reg_sel;

   cmd_type    cmd;
   status_type status;

   // register file: word address bit selects the register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         half_load_ff  <= HALF_LOAD_RESET;
         part_count_ff <= PART_COUNT_RESET;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_HALF_LOAD:  half_load_ff  <= csr_pwdata[LIMIT_W-1:0];
            REG_PART_COUNT: part_count_ff <= csr_pwdata[PCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_HALF_LOAD:  csr_prdata = half_load_ff;
         REG_PART_COUNT: csr_prdata = {{(CSR_DATA_W-PCNT_W){1'b0}}, part_count_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer: steps one edge through capture, decide, scan, update and finish
   epa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // counters, choice logic and output register
   epa_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_tdata       (req_tdata),
      .half_load_limit (half_load_ff),
      .partition_count (part_count_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser)
   );

endmodule
